/* rtl/core/ihcp_pkg.sv */
// ihcp_pkg: shared types and constants for the ip header chain parser
// used by ip_header_chain_parser_unit and its port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ihcp_pkg;

	localparam int POSITION_BITS = 16;
	localparam int CMP_BITS = (POSITION_BITS + 1 > 17) ? POSITION_BITS + 1 : 17;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	localparam logic [15:0] OFF_MAX = 16'hFFFF;
	localparam logic [15:0] V6_BASE = 16'd40;

	localparam logic [3:0] VER_4 = 4'd4;
	localparam logic [3:0] VER_6 = 4'd6;

	localparam logic [7:0] NH_HOP_BY_HOP = 8'd0;
	localparam logic [7:0] NH_ROUTING    = 8'd43;
	localparam logic [7:0] NH_FRAGMENT   = 8'd44;
	localparam logic [7:0] NH_AUTH       = 8'd51;
	localparam logic [7:0] NH_NONE       = 8'd59;
	localparam logic [7:0] NH_DEST_OPTS  = 8'd60;
	localparam logic [7:0] NH_MOBILITY   = 8'd135;

	localparam logic [3:0] V4_PROTO_POS = 4'd9;
	localparam logic [3:0] V4_MIN_LEN   = 4'd10;
	localparam logic [2:0] V6_NH_POS    = 3'd6;
	localparam logic [2:0] V6_MIN_LEN   = 3'd7;

	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_NO_NEXT   = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_NOT_IP    = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic [3:0]  ip_version;
		logic [7:0]  transport_protocol;
		logic [15:0] transport_offset;
		logic [1:0]  parse_status;
	} out_word_t;

endpackage

`default_nettype wire

/* rtl/core/ip_header_chain_parser_unit.sv */
// ip_header_chain_parser_unit: byte-serial ipv4/ipv6 header and extension chain parser
// depends on ihcp_pkg for word types, protocol numbers and status codes
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet byte per cycle, starting at the first byte of the IP header, and on
// the byte marked last gives one result word: version, transport protocol, transport
// header offset and a status (found, no next header, truncated or overflow, not IP).
// IPv6 extension headers are walked on the fly as their length bytes go by: a byte
// is held in an input register, the header state and the result are updated from it
// by a compare-and-add step, and the result is shown from an output register that is
// loaded when the last byte leaves the input register. Bytes are taken every cycle;
// the input stalls only while a finished result waits for out_ready and the next last
// byte is ready to replace it.
module ip_header_chain_parser_unit (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire ihcp_pkg::in_word_t  in_word,
	output logic                     out_valid,
	input  wire                      out_ready,
	output ihcp_pkg::out_word_t      out_word
);

	localparam int PB = ihcp_pkg::POSITION_BITS;
	localparam int CB = ihcp_pkg::CMP_BITS;

	function automatic logic is_ext_hdr(input logic [7:0] nh);
		is_ext_hdr = (nh == ihcp_pkg::NH_HOP_BY_HOP) || (nh == ihcp_pkg::NH_ROUTING) ||
			(nh == ihcp_pkg::NH_FRAGMENT) || (nh == ihcp_pkg::NH_AUTH) ||
			(nh == ihcp_pkg::NH_DEST_OPTS) || (nh == ihcp_pkg::NH_MOBILITY);
	endfunction

	// input stage
	logic                valid_s1;
	ihcp_pkg::in_word_t  word_s1;

	// parse state
	logic [PB-1:0] pos_q;
	logic [3:0]    ver_q;
	logic [3:0]    hw_q;
	logic [7:0]    cnh_q;
	logic [7:0]    pnh_q;
	logic [15:0]   hs_q;
	logic          fin_q;
	logic [1:0]    fst_q;

	logic                out_valid_q;
	ihcp_pkg::out_word_t out_q;

	logic          fire;
	logic [PB-1:0] pos_n;
	logic [3:0]    ver_n;
	logic [3:0]    hw_n;
	logic [7:0]    cnh_n;
	logic [7:0]    pnh_n;
	logic [15:0]   hs_n;
	logic          fin_n;
	logic [1:0]    fst_n;
	logic          long_pkt;
	logic [CB-1:0] p_x;
	logic [CB-1:0] hs_x;
	logic [CB-1:0] len_x;
	logic [16:0]   next_hs;
	logic [7:0]    b;
	logic [5:0]    v4_off;
	ihcp_pkg::out_word_t res;

	assign fire     = valid_s1 && (!word_s1.last_byte || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	assign b     = word_s1.data_byte;
	assign p_x   = CB'(pos_q);
	assign hs_x  = CB'(hs_q);
	assign len_x = CB'(pos_q) + CB'(1);

	always_comb begin
		if (cnh_q == ihcp_pkg::NH_AUTH) begin
			next_hs = {1'b0, hs_q} + 17'd8 + {7'd0, b, 2'b00};
		end else begin
			next_hs = {1'b0, hs_q} + 17'd8 + {6'd0, b, 3'b000};
		end
	end

	always_comb begin
		pos_n = pos_q;
		ver_n = ver_q;
		hw_n  = hw_q;
		cnh_n = cnh_q;
		pnh_n = pnh_q;
		hs_n  = hs_q;
		fin_n = fin_q;
		fst_n = fst_q;
		long_pkt = fin_q && (fst_q == ihcp_pkg::ST_TRUNCATED) && (ver_q != ihcp_pkg::VER_6);

		if (pos_q == '0) begin
			ver_n = b[7:4];
			hw_n  = b[3:0];
		end else if (ver_q == ihcp_pkg::VER_4 && pos_q == PB'(ihcp_pkg::V4_PROTO_POS)) begin
			cnh_n = b;
		end else if (ver_q == ihcp_pkg::VER_6 && !fin_q) begin
			if (pos_q == PB'(ihcp_pkg::V6_NH_POS)) begin
				cnh_n = b;
			end else if (p_x == hs_x) begin
				if (is_ext_hdr(cnh_q)) begin
					pnh_n = b;
				end else begin
					fin_n = 1'b1;
					fst_n = (cnh_q == ihcp_pkg::NH_NONE) ? ihcp_pkg::ST_NO_NEXT
						: ihcp_pkg::ST_FOUND;
				end
			end else if (p_x == hs_x + CB'(1)) begin
				cnh_n = pnh_q;
				if (next_hs[16]) begin
					hs_n  = ihcp_pkg::OFF_MAX;
					fin_n = 1'b1;
					fst_n = ihcp_pkg::ST_TRUNCATED;
				end else begin
					hs_n = next_hs[15:0];
				end
			end
		end

		if (pos_q == ihcp_pkg::POS_MAX) begin
			if (!word_s1.last_byte) begin
				fin_n = 1'b1;
				fst_n = ihcp_pkg::ST_TRUNCATED;
			end
		end else begin
			pos_n = pos_q + PB'(1);
		end
	end

	assign v4_off = {hw_n, 2'b00};

	always_comb begin
		res.ip_version         = ver_n;
		res.transport_protocol = 8'd0;
		res.transport_offset   = 16'd0;
		res.parse_status       = ihcp_pkg::ST_NOT_IP;
		if (ver_n == ihcp_pkg::VER_4) begin
			res.transport_protocol = cnh_n;
			res.transport_offset   = 16'(v4_off);
			res.parse_status = (long_pkt || len_x < CB'(ihcp_pkg::V4_MIN_LEN) ||
				len_x < CB'(v4_off)) ? ihcp_pkg::ST_TRUNCATED : ihcp_pkg::ST_FOUND;
		end else if (ver_n == ihcp_pkg::VER_6) begin
			res.transport_protocol = cnh_n;
			res.transport_offset   = hs_n;
			if (fin_n) begin
				res.parse_status = fst_n;
			end else if (cnh_n == ihcp_pkg::NH_NONE && CB'(hs_n) <= len_x &&
					len_x >= CB'(ihcp_pkg::V6_MIN_LEN)) begin
				res.parse_status = ihcp_pkg::ST_NO_NEXT;
			end else begin
				res.parse_status = ihcp_pkg::ST_TRUNCATED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ver_q <= 4'd0;
			hw_q  <= 4'd0;
			cnh_q <= 8'd0;
			pnh_q <= 8'd0;
			hs_q  <= ihcp_pkg::V6_BASE;
			fin_q <= 1'b0;
			fst_q <= ihcp_pkg::ST_FOUND;
		end else if (fire) begin
			if (word_s1.last_byte) begin
				pos_q <= '0;
				ver_q <= 4'd0;
				hw_q  <= 4'd0;
				cnh_q <= 8'd0;
				pnh_q <= 8'd0;
				hs_q  <= ihcp_pkg::V6_BASE;
				fin_q <= 1'b0;
				fst_q <= ihcp_pkg::ST_FOUND;
			end else begin
				pos_q <= pos_n;
				ver_q <= ver_n;
				hw_q  <= hw_n;
				cnh_q <= cnh_n;
				pnh_q <= pnh_n;
				hs_q  <= hs_n;
				fin_q <= fin_n;
				fst_q <= fst_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && word_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && word_s1.last_byte) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/ihcp_port_checker.sv */
// ihcp_port_checker: port-level assertions for ip_header_chain_parser_unit
// depends on ihcp_pkg; bound to ip_header_chain_parser_unit at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module ihcp_port_checker (
	input wire                      clk,
	input wire                      arst_n,
	input wire                      out_valid,
	input wire                      out_ready,
	input wire ihcp_pkg::out_word_t out_word
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word dropped or changed while stalled");

	// not-ip word carries no protocol or offset, and only bad versions give it
	a_not_ip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.parse_status == ihcp_pkg::ST_NOT_IP |->
		out_word.transport_protocol == 8'd0 && out_word.transport_offset == 16'd0 &&
		out_word.ip_version != ihcp_pkg::VER_4 && out_word.ip_version != ihcp_pkg::VER_6)
		else $error("not-ip word inconsistent");

	// ipv6 transport never starts before the fixed header ends
	a_v6_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.ip_version == ihcp_pkg::VER_6 |->
		out_word.transport_offset >= ihcp_pkg::V6_BASE)
		else $error("ipv6 offset below fixed header");

	// no next header status only with protocol 59 on ipv6
	a_no_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.parse_status == ihcp_pkg::ST_NO_NEXT |->
		out_word.transport_protocol == ihcp_pkg::NH_NONE &&
		out_word.ip_version == ihcp_pkg::VER_6)
		else $error("no-next-header status with wrong protocol");

endmodule

bind ip_header_chain_parser_unit ihcp_port_checker u_ihcp_port_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);

`default_nettype wire

/* dv/ip_header_chain_parser_checker.sv */
// ip_header_chain_parser_checker: watches both word channels of the parser, predicts results
// from accepted input words and compares them with accepted output words
// depends on ihcp_pkg for word types, protocol numbers and status codes
`timescale 1ns / 1ps

module ip_header_chain_parser_checker
	import ihcp_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  wire       in_ready,
	input  in_word_t  in_word,
	input  wire       out_valid,
	input  wire       out_ready,
	input  out_word_t out_word,
	output int        mismatch_count,
	output int        results_due
);

	localparam int unsigned LAST_POSITION = (1 << POSITION_BITS) - 1;

	out_word_t expected_results[$];

	int unsigned position;
	int unsigned version;
	int unsigned ihl_words;
	int unsigned cur_nh;
	int unsigned pend_nh;
	int unsigned hdr_start;
	bit          walk_done;
	logic [1:0]  walk_status;

	function automatic bit is_extension(input int unsigned nh);
		return nh == NH_HOP_BY_HOP || nh == NH_ROUTING || nh == NH_FRAGMENT ||
			nh == NH_AUTH || nh == NH_DEST_OPTS || nh == NH_MOBILITY;
	endfunction

	function void clear_walk();
		position = 0;
		version = 0;
		ihl_words = 0;
		cur_nh = 0;
		pend_nh = 0;
		hdr_start = V6_BASE;
		walk_done = 1'b0;
		walk_status = ST_FOUND;
	endfunction

	function void take_byte(input in_word_t w);
		int unsigned b;
		int unsigned p;
		int unsigned pkt_len;
		int unsigned next_start;
		bit          long_pkt;
		out_word_t   r;
		b = w.data_byte;
		p = position;
		long_pkt = walk_done && walk_status == ST_TRUNCATED && version != VER_6;
		if (p == 0) begin
			version = b >> 4;
			ihl_words = b & 15;
		end else if (version == VER_4 && p == V4_PROTO_POS) begin
			cur_nh = b;
		end else if (version == VER_6 && !walk_done) begin
			if (p == V6_NH_POS) begin
				cur_nh = b;
			end else if (p == hdr_start) begin
				if (is_extension(cur_nh))
					pend_nh = b;
				else begin
					walk_done = 1'b1;
					walk_status = (cur_nh == NH_NONE) ? ST_NO_NEXT : ST_FOUND;
				end
			end else if (p == hdr_start + 1) begin
				next_start = hdr_start + 8 + b * ((cur_nh == NH_AUTH) ? 4 : 8);
				cur_nh = pend_nh;
				if (next_start > OFF_MAX) begin
					hdr_start = OFF_MAX;
					walk_done = 1'b1;
					walk_status = ST_TRUNCATED;
				end else
					hdr_start = next_start;
			end
		end
		if (p == LAST_POSITION) begin
			if (!w.last_byte) begin
				long_pkt = 1'b1;
				walk_done = 1'b1;
				walk_status = ST_TRUNCATED;
			end
		end else
			position = p + 1;
		if (w.last_byte) begin
			pkt_len = p + 1;
			r.ip_version = version[3:0];
			r.transport_protocol = '0;
			r.transport_offset = '0;
			if (version == VER_4) begin
				r.transport_protocol = cur_nh[7:0];
				r.transport_offset = 16'(ihl_words * 4);
				r.parse_status = (long_pkt || pkt_len < V4_MIN_LEN || pkt_len < ihl_words * 4) ?
					ST_TRUNCATED : ST_FOUND;
			end else if (version == VER_6) begin
				r.transport_protocol = cur_nh[7:0];
				r.transport_offset = hdr_start[15:0];
				if (walk_done)
					r.parse_status = walk_status;
				else if (cur_nh == NH_NONE && hdr_start <= pkt_len && pkt_len >= V6_MIN_LEN)
					r.parse_status = ST_NO_NEXT;
				else
					r.parse_status = ST_TRUNCATED;
			end else
				r.parse_status = ST_NOT_IP;
			expected_results.push_back(r);
			clear_walk();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			expected_results.delete();
			clear_walk();
			mismatch_count = 0;
			results_due = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result word with none expected: ver %0d proto %0d off %0d st %0d",
							$time, out_word.ip_version, out_word.transport_protocol,
							out_word.transport_offset, out_word.parse_status);
				end else begin
					want = expected_results.pop_front();
					if (want.ip_version !== out_word.ip_version ||
						want.transport_protocol !== out_word.transport_protocol ||
						want.transport_offset !== out_word.transport_offset ||
						want.parse_status !== out_word.parse_status) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%0t: mismatch: expected ver %0d proto %0d off %0d st %0d, got ver %0d proto %0d off %0d st %0d",
								$time, want.ip_version, want.transport_protocol,
								want.transport_offset, want.parse_status,
								out_word.ip_version, out_word.transport_protocol,
								out_word.transport_offset, out_word.parse_status);
					end
				end
			end
			if (in_valid && in_ready)
				take_byte(in_word);
			results_due = expected_results.size();
		end
	end

endmodule

/* dv/tb_ip_header_chain_parser_unit.sv */
// tb_ip_header_chain_parser_unit: drives packets into the ip header chain parser with random
// gaps and output stalls, and gives the verdict from the checker's mismatch count
// depends on ihcp_pkg, ip_header_chain_parser_unit and ip_header_chain_parser_checker
`timescale 1ns / 1ps

module tb_ip_header_chain_parser_unit;

	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 3000;
	localparam int ITEM_TARGET = 1350;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ihcp_pkg::in_word_t  in_word = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ihcp_pkg::out_word_t out_word;
	int                  mismatch_count;
	int                  results_due;

	logic [7:0] pkt[$];
	logic [7:0] chain_nh;
	int         burst_left = 0;
	int         sent_bytes = 0;
	bit         hold_request = 1'b0;
	bit         hold_active = 1'b0;
	int         idle_cycles = 0;

	ip_header_chain_parser_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	ip_header_chain_parser_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word),
		.mismatch_count(mismatch_count),
		.results_due(results_due)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// receiver: stretches of steady, mostly ready or mostly stalled out_ready
	initial begin
		int mode;
		int stretch;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end
			mode = $urandom_range(0, 2);
			stretch = $urandom_range(1, 64);
			while (stretch > 0 && !hold_request) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 9) < 7);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
				stretch--;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input bit is_last);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		in_word <= '{data_byte: b, last_byte: is_last};
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic send_packet();
		sent_bytes += pkt.size();
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
	endtask

	task automatic fill(input int n);
		repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic cut_to(input int n);
		while (pkt.size() > n) pkt.pop_back();
	endtask

	task automatic start_v4(input logic [3:0] ihl, input logic [7:0] proto, input int total);
		pkt.delete();
		pkt.push_back({ihcp_pkg::VER_4, ihl});
		fill(total - 1);
		if (total > ihcp_pkg::V4_PROTO_POS)
			pkt[ihcp_pkg::V4_PROTO_POS] = proto;
	endtask

	task automatic start_v6(input logic [7:0] nh);
		logic [3:0] tc;
		tc = 4'($urandom_range(0, 15));
		pkt.delete();
		pkt.push_back({ihcp_pkg::VER_6, tc});
		fill(39);
		pkt[ihcp_pkg::V6_NH_POS] = nh;
		chain_nh = nh;
	endtask

	// appends one extension header of the type named by the previous next-header
	task automatic add_ext(input logic [7:0] nh, input logic [7:0] len);
		pkt.push_back(nh);
		pkt.push_back(len);
		fill(6 + len * ((chain_nh == ihcp_pkg::NH_AUTH) ? 4 : 8));
		chain_nh = nh;
	endtask

	task automatic send_raw(input logic [7:0] first, input int total);
		pkt.delete();
		pkt.push_back(first);
		fill(total - 1);
		send_packet();
	endtask

	function automatic logic [7:0] pick_ext();
		case ($urandom_range(0, 5))
			0: return ihcp_pkg::NH_HOP_BY_HOP;
			1: return ihcp_pkg::NH_ROUTING;
			2: return ihcp_pkg::NH_FRAGMENT;
			3: return ihcp_pkg::NH_AUTH;
			4: return ihcp_pkg::NH_DEST_OPTS;
			default: return ihcp_pkg::NH_MOBILITY;
		endcase
	endfunction

	function automatic logic [7:0] pick_final();
		case ($urandom_range(0, 4))
			0: return 8'd6;
			1: return 8'd17;
			2: return ihcp_pkg::NH_NONE;
			3: return 8'd58;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [7:0] ext_list[$];
		logic [7:0] final_nh;
		int n_ext;
		int kind;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not ip
		send_raw(8'h00, 1);
		send_raw(8'hFF, 5);
		send_raw({4'd5, 4'd5}, 30);

		// ipv4: complete, short before protocol byte, short before ihl*4, small ihl
		start_v4(4'd5, 8'd6, 20);
		send_packet();
		start_v4(4'd15, 8'd17, 60);
		send_packet();
		start_v4(4'd15, 8'd17, 20);
		send_packet();
		start_v4(4'd5, 8'd6, 9);
		send_packet();
		start_v4(4'd0, 8'd255, 10);
		send_packet();

		// ipv6: short headers, bare payloads, no next header at the end
		start_v6(8'd6);
		cut_to(3);
		send_packet();
		start_v6(8'd6);
		cut_to(6);
		send_packet();
		start_v6(8'd6);
		cut_to(7);
		send_packet();
		start_v6(ihcp_pkg::NH_NONE);
		send_packet();
		start_v6(ihcp_pkg::NH_NONE);
		fill(1);
		send_packet();
		start_v6(8'd6);
		fill(20);
		send_packet();

		// each extension type once
		ext_list = '{ihcp_pkg::NH_HOP_BY_HOP, ihcp_pkg::NH_ROUTING, ihcp_pkg::NH_FRAGMENT,
			ihcp_pkg::NH_DEST_OPTS, ihcp_pkg::NH_MOBILITY, ihcp_pkg::NH_AUTH};
		foreach (ext_list[i]) begin
			start_v6(ext_list[i]);
			add_ext(8'd17, 8'd1);
			fill(8);
			send_packet();
		end

		// chain cut inside an extension, extension ending exactly at the end, long auth header
		start_v6(ihcp_pkg::NH_HOP_BY_HOP);
		add_ext(8'd6, 8'd2);
		cut_to(45);
		send_packet();
		start_v6(ihcp_pkg::NH_DEST_OPTS);
		add_ext(8'd6, 8'd0);
		send_packet();
		start_v6(ihcp_pkg::NH_DEST_OPTS);
		add_ext(ihcp_pkg::NH_NONE, 8'd0);
		send_packet();
		start_v6(ihcp_pkg::NH_AUTH);
		add_ext(8'd6, 8'd64);
		fill(4);
		send_packet();

		// long receiver hold-off while short packets keep coming
		hold_request = 1'b1;
		wait (hold_active);
		repeat (40) send_raw(8'($urandom_range(0, 255)), $urandom_range(1, 3));

		while (sent_bytes < ITEM_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				n_ext = $urandom_range(0, 4);
				ext_list.delete();
				repeat (n_ext) ext_list.push_back(pick_ext());
				final_nh = pick_final();
				start_v6((n_ext > 0) ? ext_list[0] : final_nh);
				for (int i = 0; i < n_ext; i++)
					add_ext((i + 1 < n_ext) ? ext_list[i + 1] : final_nh,
						8'($urandom_range(0, 3)));
				fill($urandom_range(0, 24));
				if ($urandom_range(0, 3) == 0)
					cut_to($urandom_range(1, pkt.size()));
			end else if (kind < 8) begin
				start_v4(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					$urandom_range(1, 70));
			end else begin
				pkt.delete();
				fill($urandom_range(1, 20));
			end
			send_packet();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (results_due == 0);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
